@@ hdl/pftd_pkg.sv @@
// shared types, microcode table and prime table for the trial division factorizer
// no dependencies; used by pftd_div, pftd_seq and prime_factor_trial_division_core
package pftd_pkg;

  // program counter width and step addresses
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] STEP_SMALL     = 4'd1;
  localparam logic [PC_W-1:0] STEP_TRY       = 4'd2;
  localparam logic [PC_W-1:0] STEP_DIV_WAIT  = 4'd3;
  localparam logic [PC_W-1:0] STEP_FACTOR    = 4'd4;
  localparam logic [PC_W-1:0] STEP_AGAIN     = 4'd5;
  localparam logic [PC_W-1:0] STEP_NEXT      = 4'd6;
  localparam logic [PC_W-1:0] STEP_LEFTOVER  = 4'd7;
  localparam logic [PC_W-1:0] STEP_EMIT_REM  = 4'd8;

  // result budget per item and table sizes
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 5;
  localparam int IDX_W       = 6;
  localparam int PRIME_W     = 9;
  localparam int FIELD_W     = 32;

  // hold condition of a step
  typedef enum logic [1:0] {
    W_NONE,
    W_INPUT,
    W_DIV,
    W_OUT
  } wait_sel_t;

  // datapath action fired when a step advances
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV_START,
    ACT_EMIT_FACTOR,
    ACT_NEXT_PRIME,
    ACT_EMIT_REM
  } action_t;

  // jump condition of a step
  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_R_LE1,
    J_LOOP_DONE,
    J_REM_NZ,
    J_Q_ONE
  } jump_sel_t;

  typedef struct packed {
    wait_sel_t       wait_sel;
    action_t         act;
    jump_sel_t       jump_sel;
    logic [PC_W-1:0] target;
  } ucode_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic    fire;
    action_t act;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_full;
    logic r_le1;
    logic loop_done;
    logic rem_nz;
    logic q_one;
  } status_t;

  // microcode program
  function automatic ucode_word_t ucode_fetch(input logic [PC_W-1:0] pc);
    ucode_word_t w;
    case (pc)
      STEP_IDLE:     w = '{W_INPUT, ACT_LOAD,        J_NONE,      STEP_IDLE};
      STEP_SMALL:    w = '{W_NONE,  ACT_NONE,        J_R_LE1,     STEP_EMIT_REM};
      STEP_TRY:      w = '{W_NONE,  ACT_DIV_START,   J_LOOP_DONE, STEP_LEFTOVER};
      STEP_DIV_WAIT: w = '{W_DIV,   ACT_NONE,        J_REM_NZ,    STEP_NEXT};
      STEP_FACTOR:   w = '{W_OUT,   ACT_EMIT_FACTOR, J_Q_ONE,     STEP_IDLE};
      STEP_AGAIN:    w = '{W_NONE,  ACT_NONE,        J_ALWAYS,    STEP_TRY};
      STEP_NEXT:     w = '{W_NONE,  ACT_NEXT_PRIME,  J_ALWAYS,    STEP_TRY};
      STEP_LEFTOVER: w = '{W_NONE,  ACT_NONE,        J_R_LE1,     STEP_IDLE};
      STEP_EMIT_REM: w = '{W_OUT,   ACT_EMIT_REM,    J_ALWAYS,    STEP_IDLE};
      default:       w = '{W_NONE,  ACT_NONE,        J_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

  // prime table, 2 to 293
  function automatic logic [PRIME_W-1:0] prime_at(input logic [IDX_W-1:0] idx);
    logic [PRIME_W-1:0] p;
    case (idx)
      6'd0:  p = 9'd2;   6'd1:  p = 9'd3;   6'd2:  p = 9'd5;   6'd3:  p = 9'd7;
      6'd4:  p = 9'd11;  6'd5:  p = 9'd13;  6'd6:  p = 9'd17;  6'd7:  p = 9'd19;
      6'd8:  p = 9'd23;  6'd9:  p = 9'd29;  6'd10: p = 9'd31;  6'd11: p = 9'd37;
      6'd12: p = 9'd41;  6'd13: p = 9'd43;  6'd14: p = 9'd47;  6'd15: p = 9'd53;
      6'd16: p = 9'd59;  6'd17: p = 9'd61;  6'd18: p = 9'd67;  6'd19: p = 9'd71;
      6'd20: p = 9'd73;  6'd21: p = 9'd79;  6'd22: p = 9'd83;  6'd23: p = 9'd89;
      6'd24: p = 9'd97;  6'd25: p = 9'd101; 6'd26: p = 9'd103; 6'd27: p = 9'd107;
      6'd28: p = 9'd109; 6'd29: p = 9'd113; 6'd30: p = 9'd127; 6'd31: p = 9'd131;
      6'd32: p = 9'd137; 6'd33: p = 9'd139; 6'd34: p = 9'd149; 6'd35: p = 9'd151;
      6'd36: p = 9'd157; 6'd37: p = 9'd163; 6'd38: p = 9'd167; 6'd39: p = 9'd173;
      6'd40: p = 9'd179; 6'd41: p = 9'd181; 6'd42: p = 9'd191; 6'd43: p = 9'd193;
      6'd44: p = 9'd197; 6'd45: p = 9'd199; 6'd46: p = 9'd211; 6'd47: p = 9'd223;
      6'd48: p = 9'd227; 6'd49: p = 9'd229; 6'd50: p = 9'd233; 6'd51: p = 9'd239;
      6'd52: p = 9'd241; 6'd53: p = 9'd251; 6'd54: p = 9'd257; 6'd55: p = 9'd263;
      6'd56: p = 9'd269; 6'd57: p = 9'd271; 6'd58: p = 9'd277; 6'd59: p = 9'd281;
      6'd60: p = 9'd283; 6'd61: p = 9'd293;
      default: p = 9'd2;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/pftd_div.sv @@
// restoring divider of a wide value by a 9-bit table prime, one quotient bit per cycle
// depends on pftd_pkg for the divisor width
module pftd_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [VALUE_WIDTH-1:0]         dividend,
  input  logic [pftd_pkg::PRIME_W-1:0]   divisor,
  output logic                           busy,
  output logic [VALUE_WIDTH-1:0]         quotient,
  output logic                           rem_nz
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int PW = pftd_pkg::PRIME_W;

  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] work;
  logic [PW-1:0]          rem;
  logic [PW:0]            trial;
  logic                   fits;

  // one restoring step: shift in the next dividend bit and try a subtract
  assign trial = {rem, work[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(VALUE_WIDTH);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  // shared register holds the dividend and collects the quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[VALUE_WIDTH-2:0], fits};
      rem  <= fits ? PW'(trial - {1'b0, divisor}) : trial[PW-1:0];
    end
  end

  assign busy     = cnt != '0;
  assign quotient = work;
  assign rem_nz   = rem != '0;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");

endmodule

@@ hdl/pftd_seq.sv @@
// microcode sequencer: step counter, program table fetch, hold and jump logic
// depends on pftd_pkg for the program and the control and status structs
module pftd_seq (
  input  logic              clk,
  input  logic              rst,
  input  pftd_pkg::status_t st,
  output pftd_pkg::ctrl_t   ctrl
);

  logic [pftd_pkg::PC_W-1:0] pc;
  logic [pftd_pkg::PC_W-1:0] pc_next;
  pftd_pkg::ucode_word_t     word;
  logic                      hold;
  logic                      take;

  assign word = pftd_pkg::ucode_fetch(pc);

  // hold condition of the current step
  always_comb begin
    case (word.wait_sel)
      pftd_pkg::W_NONE:  hold = 1'b0;
      pftd_pkg::W_INPUT: hold = !st.in_valid;
      pftd_pkg::W_DIV:   hold = st.div_busy;
      pftd_pkg::W_OUT:   hold = st.out_full;
      default:           hold = 1'b0;
    endcase
  end

  // jump condition of the current step
  always_comb begin
    case (word.jump_sel)
      pftd_pkg::J_NONE:      take = 1'b0;
      pftd_pkg::J_ALWAYS:    take = 1'b1;
      pftd_pkg::J_R_LE1:     take = st.r_le1;
      pftd_pkg::J_LOOP_DONE: take = st.loop_done;
      pftd_pkg::J_REM_NZ:    take = st.rem_nz;
      pftd_pkg::J_Q_ONE:     take = st.q_one;
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + pftd_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pftd_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.fire = !hold;
  assign ctrl.act  = word.act;

  a_load_then_small: assert property (@(posedge clk) disable iff (rst)
    (ctrl.fire && ctrl.act == pftd_pkg::ACT_LOAD) |=> pc == pftd_pkg::STEP_SMALL)
    else $error("load step did not advance to the small-value check");

endmodule

@@ hdl/prime_factor_trial_division_core.sv @@
// trials: each trial division runs the one-bit-per-cycle divider; an item takes
// at most NUM_PRIMES+31 trials
// throughput: one item at a time; the next transaction is taken once the last result is queued
// the output register lets the final result wait while the next item is accepted
// reset: synchronous, clears the sequencer to idle, the divider count and output valid
module prime_factor_trial_division_core #(
  parameter int NUM_PRIMES  = 62,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        value_valid,
  output logic        value_stall,
  input  logic [31:0] value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] factor,
  output logic        is_remainder,
  output logic        last
);

  localparam int IW = pftd_pkg::IDX_W;
  localparam int NW = pftd_pkg::CNT_W;
  localparam logic [IW-1:0] LIMIT    = IW'(NUM_PRIMES);
  localparam logic [NW-1:0] LAST_CNT = NW'(pftd_pkg::MAX_RESULTS - 1);

  pftd_pkg::ctrl_t   ctrl;
  pftd_pkg::status_t st;

  logic [VALUE_WIDTH-1:0]       remaining;
  logic [IW-1:0]                idx;
  logic [NW-1:0]                n;
  logic [pftd_pkg::PRIME_W-1:0] prime;
  logic                         div_start;
  logic                         div_busy;
  logic [VALUE_WIDTH-1:0]       quotient;
  logic                         rem_nz;
  logic                         out_full;
  logic                         emit;
  logic                         q_one;

  // the divider starts only when the trial loop goes on
  assign prime     = pftd_pkg::prime_at(idx);
  assign div_start = ctrl.fire && ctrl.act == pftd_pkg::ACT_DIV_START && !st.loop_done;
  assign out_full  = result_valid && result_stall;
  assign q_one     = quotient == VALUE_WIDTH'(1);
  assign emit      = ctrl.fire && (ctrl.act == pftd_pkg::ACT_EMIT_FACTOR ||
                                   ctrl.act == pftd_pkg::ACT_EMIT_REM);

  // input is taken only by the load step
  assign value_stall = ctrl.act != pftd_pkg::ACT_LOAD;

  pftd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  pftd_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (remaining),
    .divisor  (prime),
    .busy     (div_busy),
    .quotient (quotient),
    .rem_nz   (rem_nz)
  );

  // status back to the sequencer
  assign st.in_valid  = value_valid;
  assign st.div_busy  = div_busy;
  assign st.out_full  = out_full;
  assign st.r_le1     = remaining <= VALUE_WIDTH'(1);
  assign st.loop_done = idx == LIMIT || n == LAST_CNT;
  assign st.rem_nz    = rem_nz;
  assign st.q_one     = q_one;

  // working value, prime index and result count
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.act)
        pftd_pkg::ACT_LOAD: begin
          remaining <= VALUE_WIDTH'(value);
          idx       <= '0;
          n         <= '0;
        end
        pftd_pkg::ACT_NEXT_PRIME: begin
          idx <= idx + IW'(1);
        end
        pftd_pkg::ACT_EMIT_FACTOR: begin
          remaining <= quotient;
          n         <= n + NW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctrl.act == pftd_pkg::ACT_EMIT_FACTOR) begin
        factor       <= 32'(prime);
        is_remainder <= 1'b0;
        last         <= q_one;
      end else begin
        factor       <= 32'(remaining);
        is_remainder <= 1'b1;
        last         <= 1'b1;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) emit |-> !out_full)
    else $error("result overwritten while stalled");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.fire && ctrl.act == pftd_pkg::ACT_NEXT_PRIME) |-> idx < LIMIT)
    else $error("prime index stepped past the table limit");

endmodule
